// ===== rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    localparam int COLOR_W = 4;

    // control part of one point job handed from the core to the emitter
    typedef struct packed {
        logic               idle;
        logic               done;
        logic [COLOR_W-1:0] col;
    } t_job_ctl;

    localparam logic [COLOR_W-1:0] COLOR_FIRST = 4'd1;
    localparam logic [COLOR_W:0]   COLOR_LIMIT = 5'd15;
    localparam logic [1:0]         PIX_LAST    = 2'd3;

endpackage

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// Step item: queued, loaded into the emitter, sent from its output register,
//   one pixel per cycle while the receiver is ready; the one-pixel port sets
//   step rate. Start item: no result; holds the walker in S1-S4 on the shared
//   multiplier, plus R0-R5 if a radius is zero; region 2 entry adds R0-R5.
// Reset: synchronous, active low; clears control state only, no clearing pass.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse rasterizer: input queue, walker core and pixel emitter.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [COORD_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS-1:0]         i_center_y,
    input  logic [RADIUS_BITS-1:0]        i_radius_x,
    input  logic [RADIUS_BITS-1:0]        i_radius_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS+1:0]  o_pixel_x,
    output logic signed [COORD_BITS+1:0]  o_pixel_y,
    output logic [mer_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                          o_last_of_point,
    output logic                          o_drawing_done,
    output logic                          o_idle_reply
);
    import mer_pkg::*;

    logic                          cmd_valid;
    logic                          pop;
    t_cmd                          cmd;
    logic [COORD_BITS-1:0]         q_cx, q_cy, j_cx, j_cy;
    logic [RADIUS_BITS-1:0]        q_rx, q_ry;
    logic                          emit_free;
    logic                          load;
    t_job_ctl                      ctl;
    logic [RADIUS_BITS:0]          j_x;
    logic signed [RADIUS_BITS+1:0] j_y;

    mer_front #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .o_cmd_valid (cmd_valid),
        .i_pop       (pop),
        .o_cmd       (cmd),
        .o_cx        (q_cx),
        .o_cy        (q_cy),
        .o_rx        (q_rx),
        .o_ry        (q_ry)
    );

    mer_core #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_pop       (pop),
        .i_cmd       (cmd),
        .i_cx        (q_cx),
        .i_cy        (q_cy),
        .i_rx        (q_rx),
        .i_ry        (q_ry),
        .i_emit_free (emit_free),
        .o_load      (load),
        .o_ctl       (ctl),
        .o_cx        (j_cx),
        .o_cy        (j_cy),
        .o_x         (j_x),
        .o_y         (j_y)
    );

    mer_emit #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_ctl           (ctl),
        .i_cx            (j_cx),
        .i_cy            (j_cy),
        .i_x             (j_x),
        .i_y             (j_y),
        .o_free          (emit_free),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_last_of_point (o_last_of_point),
        .o_drawing_done  (o_drawing_done),
        .o_idle_reply    (o_idle_reply)
    );

endmodule

// ===== rtl/mer_front.sv =====
// ----------------------------------------------------------------------------
// mer_front
// Input side: accepts items, classifies them and holds them in a
// two-entry queue until the core takes them.
// ----------------------------------------------------------------------------
module mer_front #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_kind,
    input  logic [COORD_BITS-1:0]  i_center_x,
    input  logic [COORD_BITS-1:0]  i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius_x,
    input  logic [RADIUS_BITS-1:0] i_radius_y,
    output logic                   o_cmd_valid,
    input  logic                   i_pop,
    output mer_pkg::t_cmd          o_cmd,
    output logic [COORD_BITS-1:0]  o_cx,
    output logic [COORD_BITS-1:0]  o_cy,
    output logic [RADIUS_BITS-1:0] o_rx,
    output logic [RADIUS_BITS-1:0] o_ry
);
    import mer_pkg::*;

    localparam int ENT_W = 1 + 2 * COORD_BITS + 2 * RADIUS_BITS;

    logic [ENT_W-1:0] r_ent [2];
    logic [1:0]       r_cnt;
    logic             r_wp;
    logic             r_rp;
    logic             push;
    logic [ENT_W-1:0] head;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign head        = r_ent[r_rp];

    assign o_cmd = head[ENT_W-1] ? CMD_STEP : CMD_START;
    assign o_cx  = head[ENT_W-2 -: COORD_BITS];
    assign o_cy  = head[ENT_W-2-COORD_BITS -: COORD_BITS];
    assign o_rx  = head[2*RADIUS_BITS-1 -: RADIUS_BITS];
    assign o_ry  = head[RADIUS_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= {i_kind, i_center_x, i_center_y, i_radius_x, i_radius_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/mer_emit.sv =====
// ----------------------------------------------------------------------------
// mer_emit
// Output side: expands one point job into its four symmetric pixels
// (or one idle reply) through a registered output stage.
// ----------------------------------------------------------------------------
module mer_emit #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  mer_pkg::t_job_ctl             i_ctl,
    input  logic [COORD_BITS-1:0]         i_cx,
    input  logic [COORD_BITS-1:0]         i_cy,
    input  logic [RADIUS_BITS:0]          i_x,
    input  logic signed [RADIUS_BITS+1:0] i_y,
    output logic                          o_free,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS+1:0]  o_pixel_x,
    output logic signed [COORD_BITS+1:0]  o_pixel_y,
    output logic [mer_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                          o_last_of_point,
    output logic                          o_drawing_done,
    output logic                          o_idle_reply
);
    import mer_pkg::*;

    localparam int PIX_W = COORD_BITS + 2;
    localparam int X_W   = RADIUS_BITS + 1;
    localparam int Y_W   = RADIUS_BITS + 2;
    localparam int PW    = COORD_BITS + RADIUS_BITS + 3;

    logic                  r_busy;
    logic [1:0]            r_idx;
    t_job_ctl              r_ctl;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [X_W-1:0]        r_x;
    logic signed [Y_W-1:0] r_y;

    logic signed [PW-1:0] cx_w, cy_w, x_w, y_w, px_w, py_w;
    logic                 take;
    logic                 last;

    assign take   = r_busy && (!o_out_valid || i_out_ready);
    assign last   = r_ctl.idle || (r_idx == PIX_LAST);
    assign o_free = !r_busy || (take && last);

    assign cx_w = {{(PW-COORD_BITS){1'b0}}, r_cx};
    assign cy_w = {{(PW-COORD_BITS){1'b0}}, r_cy};
    assign x_w  = {{(PW-X_W){1'b0}}, r_x};
    assign y_w  = {{(PW-Y_W){r_y[Y_W-1]}}, r_y};
    // pixel order: +x+y, -x+y, +x-y, -x-y
    assign px_w = r_idx[0] ? (cx_w - x_w) : (cx_w + x_w);
    assign py_w = r_idx[1] ? (cy_w - y_w) : (cy_w + y_w);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl <= i_ctl;
            r_cx  <= i_cx;
            r_cy  <= i_cy;
            r_x   <= i_x;
            r_y   <= i_y;
        end
        if (take) begin
            if (r_ctl.idle) begin
                o_pixel_x       <= '0;
                o_pixel_y       <= '0;
                o_pixel_color   <= '0;
                o_last_of_point <= 1'b0;
                o_drawing_done  <= 1'b0;
            end else begin
                o_pixel_x       <= px_w[PIX_W-1:0];
                o_pixel_y       <= py_w[PIX_W-1:0];
                o_pixel_color   <= r_ctl.col;
                o_last_of_point <= (r_idx == PIX_LAST);
                o_drawing_done  <= r_ctl.done;
            end
            o_idle_reply <= r_ctl.idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (take) begin
                r_idx <= r_idx + 2'd1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (take) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/mer_core.sv =====
// ----------------------------------------------------------------------------
// mer_core
// Ellipse walker: takes commands from the queue, sets up the decision
// terms with one shared multiplier, advances the point and hands point
// jobs to the emitter.
// ----------------------------------------------------------------------------
module mer_core #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_pop,
    input  mer_pkg::t_cmd                 i_cmd,
    input  logic [COORD_BITS-1:0]         i_cx,
    input  logic [COORD_BITS-1:0]         i_cy,
    input  logic [RADIUS_BITS-1:0]        i_rx,
    input  logic [RADIUS_BITS-1:0]        i_ry,
    input  logic                          i_emit_free,
    output logic                          o_load,
    output mer_pkg::t_job_ctl             o_ctl,
    output logic [COORD_BITS-1:0]         o_cx,
    output logic [COORD_BITS-1:0]         o_cy,
    output logic [RADIUS_BITS:0]          o_x,
    output logic signed [RADIUS_BITS+1:0] o_y
);
    import mer_pkg::*;

    localparam int RB     = RADIUS_BITS;
    localparam int X_W    = RB + 1;
    localparam int Y_W    = RB + 2;
    localparam int SQ_W   = 2 * RB;
    localparam int SL_W   = 3 * RB + 3;
    localparam int DEC_W  = 4 * RB + 8;
    localparam int MUL_W  = 2 * RB + 4;
    localparam int PROD_W = 2 * MUL_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_S1, ST_S2, ST_S3, ST_S4,
        ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5
    } t_state;

    t_state                  r_state;
    logic                    r_active;
    logic                    r_reg2;
    logic [X_W-1:0]          r_x;
    logic signed [Y_W-1:0]   r_y;
    logic signed [SL_W-1:0]  r_sdx;
    logic signed [SL_W-1:0]  r_sdy;
    logic signed [DEC_W-1:0] r_dec;
    logic signed [DEC_W-1:0] r_acc;
    logic [COLOR_W-1:0]      r_col;
    logic [COORD_BITS-1:0]   r_cx;
    logic [COORD_BITS-1:0]   r_cy;
    logic [RB-1:0]           r_rx;
    logic [RB-1:0]           r_ry;
    logic [SQ_W-1:0]         r_rx2;
    logic [SQ_W-1:0]         r_ry2;
    logic [PROD_W-1:0]       r_prod;

    logic [MUL_W-1:0]        mul_a, mul_b;
    logic signed [SL_W-1:0]  rx2_sl, ry2_sl;
    logic signed [DEC_W-1:0] rx2_d, ry2_d, sdx_d, sdy_d, prod4_d;
    logic [X_W-1:0]          n_x;
    logic signed [Y_W-1:0]   n_y;
    logic signed [SL_W-1:0]  n_sdx, n_sdy;
    logic signed [DEC_W-1:0] n_dec;
    logic [COLOR_W:0]        col_inc;
    logic [COLOR_W-1:0]      n_col;
    logic                    sw_reg2;
    logic                    n_done;
    logic                    take_step;
    logic [Y_W-1:0]          y_m1;
    logic [Y_W-1:0]          b_abs;

    assign rx2_sl  = {{(SL_W-SQ_W){1'b0}}, r_rx2};
    assign ry2_sl  = {{(SL_W-SQ_W){1'b0}}, r_ry2};
    assign rx2_d   = {{(DEC_W-SQ_W){1'b0}}, r_rx2};
    assign ry2_d   = {{(DEC_W-SQ_W){1'b0}}, r_ry2};
    assign prod4_d = {r_prod[DEC_W-3:0], 2'b00};

    assign col_inc = {1'b0, r_col} + {{COLOR_W{1'b0}}, 1'b1};
    assign n_col   = (col_inc >= COLOR_LIMIT) ? COLOR_FIRST : col_inc[COLOR_W-1:0];

    // one step of the midpoint walk (decision kept scaled by 4)
    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_sdx = r_sdx;
        n_sdy = r_sdy;
        if (!r_reg2) begin
            n_x   = r_x + {{(X_W-1){1'b0}}, 1'b1};
            n_sdx = r_sdx + (ry2_sl <<< 1);
            if (!r_dec[DEC_W-1]) begin
                n_y   = r_y - {{(Y_W-1){1'b0}}, 1'b1};
                n_sdy = r_sdy - (rx2_sl <<< 1);
            end
        end else begin
            n_y   = r_y - {{(Y_W-1){1'b0}}, 1'b1};
            n_sdy = r_sdy - (rx2_sl <<< 1);
            if (r_dec[DEC_W-1] || r_dec == '0) begin
                n_x   = r_x + {{(X_W-1){1'b0}}, 1'b1};
                n_sdx = r_sdx + (ry2_sl <<< 1);
            end
        end
    end

    assign sdx_d = {{(DEC_W-SL_W){n_sdx[SL_W-1]}}, n_sdx};
    assign sdy_d = {{(DEC_W-SL_W){n_sdy[SL_W-1]}}, n_sdy};

    always_comb begin
        if (!r_reg2) begin
            if (r_dec[DEC_W-1]) begin
                n_dec = r_dec + ((sdx_d + ry2_d) <<< 2);
            end else begin
                n_dec = r_dec + ((sdx_d - sdy_d + ry2_d) <<< 2);
            end
        end else begin
            if (!r_dec[DEC_W-1] && r_dec != '0) begin
                n_dec = r_dec + ((rx2_d - sdy_d) <<< 2);
            end else begin
                n_dec = r_dec + ((sdx_d - sdy_d + rx2_d) <<< 2);
            end
        end
    end

    assign sw_reg2 = !r_reg2 && !(n_sdx < n_sdy);
    assign n_done  = (r_reg2 || sw_reg2) && n_y[Y_W-1];

    // |y - 1| for the region 2 set-up; y is never negative there
    assign y_m1  = r_y - {{(Y_W-1){1'b0}}, 1'b1};
    assign b_abs = (r_y == '0) ? {{(Y_W-1){1'b0}}, 1'b1} : y_m1;

    always_comb begin
        unique case (r_state)
            ST_S1: begin
                mul_a = {{(MUL_W-RB){1'b0}}, r_rx};
                mul_b = {{(MUL_W-RB){1'b0}}, r_rx};
            end
            ST_S2: begin
                mul_a = {{(MUL_W-RB){1'b0}}, r_ry};
                mul_b = {{(MUL_W-RB){1'b0}}, r_ry};
            end
            ST_S3: begin
                mul_a = {{(MUL_W-SQ_W){1'b0}}, r_rx2};
                mul_b = {{(MUL_W-RB){1'b0}}, r_ry};
            end
            ST_R0: begin
                mul_a = {{(MUL_W-X_W-1){1'b0}}, r_x, 1'b1};
                mul_b = {{(MUL_W-X_W-1){1'b0}}, r_x, 1'b1};
            end
            ST_R1: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = {{(MUL_W-SQ_W){1'b0}}, r_ry2};
            end
            ST_R2: begin
                mul_a = {{(MUL_W-Y_W){1'b0}}, b_abs};
                mul_b = {{(MUL_W-Y_W){1'b0}}, b_abs};
            end
            ST_R3: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = {{(MUL_W-SQ_W){1'b0}}, r_rx2};
            end
            ST_R4: begin
                mul_a = {{(MUL_W-SQ_W){1'b0}}, r_rx2};
                mul_b = {{(MUL_W-SQ_W){1'b0}}, r_ry2};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign take_step = (r_state == ST_IDLE) && i_cmd_valid && (i_cmd == CMD_STEP)
                       && i_emit_free;
    assign o_pop     = ((r_state == ST_IDLE) && i_cmd_valid && (i_cmd == CMD_START))
                       || take_step;
    assign o_load    = take_step;
    assign o_ctl     = '{idle: !r_active, done: n_done, col: n_col};
    assign o_cx      = r_cx;
    assign o_cy      = r_cy;
    assign o_x       = r_x;
    assign o_y       = r_y;

    always_ff @(posedge i_clk) begin
        r_prod <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
            r_reg2   <= 1'b0;
            r_col    <= COLOR_FIRST;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && i_cmd == CMD_START) begin
                        r_cx     <= i_cx;
                        r_cy     <= i_cy;
                        r_rx     <= i_rx;
                        r_ry     <= i_ry;
                        r_x      <= '0;
                        r_y      <= {2'b00, i_ry};
                        r_sdx    <= '0;
                        r_col    <= COLOR_FIRST;
                        r_reg2   <= 1'b0;
                        r_active <= 1'b1;
                        r_state  <= ST_S1;
                    end else if (take_step && r_active) begin
                        r_col <= n_col;
                        r_x   <= n_x;
                        r_y   <= n_y;
                        r_sdx <= n_sdx;
                        r_sdy <= n_sdy;
                        r_dec <= n_dec;
                        if (n_done) begin
                            r_active <= 1'b0;
                        end else if (sw_reg2) begin
                            r_state <= ST_R0;
                        end
                    end
                end
                ST_S1: r_state <= ST_S2;
                ST_S2: begin
                    r_rx2   <= r_prod[SQ_W-1:0];
                    r_state <= ST_S3;
                end
                ST_S3: begin
                    r_ry2   <= r_prod[SQ_W-1:0];
                    r_state <= ST_S4;
                end
                ST_S4: begin
                    // slope_dy = 2 rx^2 ry ; decision = 4 ry^2 - 4 rx^2 ry + rx^2
                    r_sdy   <= {r_prod[SL_W-2:0], 1'b0};
                    r_dec   <= (ry2_d <<< 2) - prod4_d + rx2_d;
                    r_state <= (r_prod[SL_W-1:0] == '0) ? ST_R0 : ST_IDLE;
                end
                ST_R0: r_state <= ST_R1;
                ST_R1: r_state <= ST_R2;
                ST_R2: begin
                    r_acc   <= r_prod[DEC_W-1:0];
                    r_state <= ST_R3;
                end
                ST_R3: r_state <= ST_R4;
                ST_R4: begin
                    r_acc   <= r_acc + prod4_d;
                    r_state <= ST_R5;
                end
                ST_R5: begin
                    r_dec   <= r_acc - prod4_d;
                    r_reg2  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/mer_checker.sv =====
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks of the midpoint ellipse rasterizer, bound to the top.
// ----------------------------------------------------------------------------
module mer_checker #(
    parameter int COORD_BITS  = 11
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_BITS+1:0]  o_pixel_x,
    input logic signed [COORD_BITS+1:0]  o_pixel_y,
    input logic [mer_pkg::COLOR_W-1:0]   o_pixel_color,
    input logic                          o_last_of_point,
    input logic                          o_drawing_done,
    input logic                          o_idle_reply
);
    import mer_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_pixel_color) && $stable(o_last_of_point))
        else $error("output changed while stalled");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_idle_reply |-> o_pixel_x == '0 && o_pixel_y == '0
            && o_pixel_color == '0 && !o_last_of_point && !o_drawing_done)
        else $error("idle reply carries pixel data");

    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_idle_reply |-> o_pixel_color >= COLOR_FIRST
            && o_pixel_color <= 4'd14)
        else $error("pixel color out of range");

    // the done flag stays on every pixel of the ellipse's final point
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_drawing_done && !o_last_of_point
            |=> !o_out_valid || o_drawing_done)
        else $error("done flag dropped inside a point");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
    .COORD_BITS  (COORD_BITS)
) u_mer_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_pixel_color   (o_pixel_color),
    .o_last_of_point (o_last_of_point),
    .o_drawing_done  (o_drawing_done),
    .o_idle_reply    (o_idle_reply)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the midpoint ellipse rasterizer. Start and step
// commands go in through a valid/ready port; every pixel that comes out is
// compared field by field against an in-bench walker model held by the
// scoreboard. A directed opening covers the corner cases, then random
// ellipses, partial walks, restarts and stray steps run under three
// sender/receiver stall profiles.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mer_pkg::*;

    localparam int COORD_BITS   = 11;
    localparam int RADIUS_BITS  = 10;
    localparam int PIX_W        = COORD_BITS + 2;
    localparam int RANDOM_ITEMS = 460;

    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [COLOR_W-1:0] col;
        logic               last;
        logic               done;
        logic               idle;
    } t_pixel;

    class ellipse_scoreboard;
        t_pixel      expected_pixels[$];
        int          errors;
        int          checked;
        int          starts;
        int          steps;
        int          idle_steps;
        int          finished;
        bit          walking;
        bit          region_two;
        longint      cur_x;
        longint      cur_y;
        longint      slope_dx;
        longint      slope_dy;
        longint      decision;
        longint      rx_sq;
        longint      ry_sq;
        longint      org_x;
        longint      org_y;
        int unsigned color;

        function new();
            walking    = 1'b0;
            region_two = 1'b0;
            cur_x      = 0;
            cur_y      = 0;
            slope_dx   = 0;
            slope_dy   = 0;
            decision   = 0;
            rx_sq      = 0;
            ry_sq      = 0;
            org_x      = 0;
            org_y      = 0;
            color      = 32'(COLOR_FIRST);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            if (errors <= 40) begin
                $display("%0t ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
            end
        endtask

        // region 2 decision is formed from the current point once the slopes cross
        function void maybe_enter_region_two();
            longint a;
            longint b;
            if (!region_two && slope_dx >= slope_dy) begin
                a          = 2 * cur_x + 1;
                b          = cur_y - 1;
                region_two = 1'b1;
                decision   = ry_sq * a * a + 4 * rx_sq * b * b - 4 * rx_sq * ry_sq;
            end
        endfunction

        function void push_pixel(longint px, longint py, logic [COLOR_W-1:0] col,
                                 bit last, bit done, bit idle);
            t_pixel p;
            p.px   = px[PIX_W-1:0];
            p.py   = py[PIX_W-1:0];
            p.col  = col;
            p.last = last;
            p.done = done;
            p.idle = idle;
            expected_pixels.push_back(p);
        endfunction

        function void note_command(t_cmd k, logic [COORD_BITS-1:0] cx,
                                   logic [COORD_BITS-1:0] cy,
                                   logic [RADIUS_BITS-1:0] rx,
                                   logic [RADIUS_BITS-1:0] ry);
            longint rxl;
            longint ryl;
            longint x0;
            longint y0;
            bit     done;
            if (k == CMD_START) begin
                rxl        = longint'(rx);
                ryl        = longint'(ry);
                org_x      = longint'(cx);
                org_y      = longint'(cy);
                rx_sq      = rxl * rxl;
                ry_sq      = ryl * ryl;
                cur_x      = 0;
                cur_y      = ryl;
                slope_dx   = 0;
                slope_dy   = 2 * rx_sq * ryl;
                decision   = 4 * ry_sq - 4 * rx_sq * ryl + rx_sq;
                color      = 32'(COLOR_FIRST);
                region_two = 1'b0;
                walking    = 1'b1;
                starts++;
                maybe_enter_region_two();
                return;
            end
            steps++;
            if (!walking) begin
                idle_steps++;
                push_pixel(0, 0, '0, 1'b0, 1'b0, 1'b1);
                return;
            end
            color = color + 1;
            if (color >= 32'(COLOR_LIMIT)) begin
                color = 32'(COLOR_FIRST);
            end
            x0 = cur_x;
            y0 = cur_y;
            if (!region_two) begin
                cur_x    += 1;
                slope_dx += 2 * ry_sq;
                if (decision < 0) begin
                    decision += 4 * (slope_dx + ry_sq);
                end else begin
                    cur_y    -= 1;
                    slope_dy -= 2 * rx_sq;
                    decision += 4 * (slope_dx - slope_dy + ry_sq);
                end
                maybe_enter_region_two();
            end else begin
                cur_y    -= 1;
                slope_dy -= 2 * rx_sq;
                if (decision > 0) begin
                    decision += 4 * (rx_sq - slope_dy);
                end else begin
                    cur_x    += 1;
                    slope_dx += 2 * ry_sq;
                    decision += 4 * (slope_dx - slope_dy + rx_sq);
                end
            end
            done = region_two && cur_y < 0;
            if (done) begin
                walking = 1'b0;
                finished++;
            end
            push_pixel(org_x + x0, org_y + y0, color[COLOR_W-1:0], 1'b0, done, 1'b0);
            push_pixel(org_x - x0, org_y + y0, color[COLOR_W-1:0], 1'b0, done, 1'b0);
            push_pixel(org_x + x0, org_y - y0, color[COLOR_W-1:0], 1'b0, done, 1'b0);
            push_pixel(org_x - x0, org_y - y0, color[COLOR_W-1:0], 1'b1, done, 1'b0);
        endfunction

        task check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                report_mismatch("pixel with none pending, x", longint'($signed(got.px)), 0);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (got.px !== want.px)
                report_mismatch("pixel_x", longint'($signed(got.px)),
                                longint'($signed(want.px)));
            if (got.py !== want.py)
                report_mismatch("pixel_y", longint'($signed(got.py)),
                                longint'($signed(want.py)));
            if (got.col !== want.col)
                report_mismatch("pixel_color", longint'(got.col), longint'(want.col));
            if (got.last !== want.last)
                report_mismatch("last_of_point", longint'(got.last), longint'(want.last));
            if (got.done !== want.done)
                report_mismatch("drawing_done", longint'(got.done), longint'(want.done));
            if (got.idle !== want.idle)
                report_mismatch("idle_reply", longint'(got.idle), longint'(want.idle));
        endtask
    endclass

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    t_cmd                      kind       = CMD_STEP;
    logic [COORD_BITS-1:0]     center_x   = '0;
    logic [COORD_BITS-1:0]     center_y   = '0;
    logic [RADIUS_BITS-1:0]    radius_x   = '0;
    logic [RADIUS_BITS-1:0]    radius_y   = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic signed [PIX_W-1:0]   pixel_x;
    logic signed [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      last_of_point;
    logic                      drawing_done;
    logic                      idle_reply;

    ellipse_scoreboard sb;
    int send_idle_pct = 11;
    int recv_idle_pct = 74;
    int n_sent        = 0;

    midpoint_ellipse_rasterizer #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (kind),
        .i_center_x      (center_x),
        .i_center_y      (center_y),
        .i_radius_x      (radius_x),
        .i_radius_y      (radius_y),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_pixel_x       (pixel_x),
        .o_pixel_y       (pixel_y),
        .o_pixel_color   (pixel_color),
        .o_last_of_point (last_of_point),
        .o_drawing_done  (drawing_done),
        .o_idle_reply    (idle_reply)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: sample at the edge, then pick the next ready
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_pixel({pixel_x, pixel_y, pixel_color, last_of_point,
                            drawing_done, idle_reply});
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // called at a clock edge; returns at the edge of the transfer
    task automatic send_item(t_cmd k, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [RADIUS_BITS-1:0] rx, logic [RADIUS_BITS-1:0] ry);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        center_x <= cx;
        center_y <= cy;
        radius_x <= rx;
        radius_y <= ry;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_command(k, cx, cy, rx, ry);
        n_sent++;
    endtask

    task automatic send_start(int cx, int cy, int rx, int ry);
        send_item(CMD_START, cx[COORD_BITS-1:0], cy[COORD_BITS-1:0],
                  rx[RADIUS_BITS-1:0], ry[RADIUS_BITS-1:0]);
    endtask

    // unused fields of a step carry random junk
    task automatic send_step();
        send_item(CMD_STEP, COORD_BITS'($urandom_range(0, 2047)),
                  COORD_BITS'($urandom_range(0, 2047)),
                  RADIUS_BITS'($urandom_range(0, 1023)),
                  RADIUS_BITS'($urandom_range(0, 1023)));
    endtask

    task automatic walk_ellipse(int max_steps);
        int n;
        n = 0;
        while (sb.walking && n < max_steps) begin
            send_step();
            n++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
    endtask

    initial begin
        int phase;
        int base;
        int pick;
        int rmax;
        int waited;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle step, extreme ellipse, restart, zero radii, small full walk
        send_step();
        send_start(2047, 2047, 1023, 1023);
        repeat (3) send_step();
        send_start(0, 0, 0, 0);
        send_step();
        send_step();
        send_start(1024, 5, 0, 3);
        walk_ellipse(8);
        send_start(7, 1024, 5, 0);
        walk_ellipse(4);
        send_start(100, 100, 3, 2);
        walk_ellipse(20);
        send_step();

        base  = n_sent;
        phase = 0;
        while (n_sent - base < RANDOM_ITEMS) begin
            if ((n_sent - base) * 3 / RANDOM_ITEMS > phase) begin
                phase++;
                drain_results();
                send_idle_pct = (phase == 1) ? 74 : 0;
                recv_idle_pct = (phase == 1) ? 11 : 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_step();
            end else if (pick < 16) begin
                // wide radii: walk a few points, then get restarted
                send_start($urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 1023), $urandom_range(0, 1023));
                repeat ($urandom_range(1, 6)) send_step();
            end else begin
                rmax = ($urandom_range(0, 9) == 0) ? 40 : 12;
                send_start($urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, rmax), $urandom_range(0, rmax));
                walk_ellipse(($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 1000);
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.expected_pixels.size() != 0 && waited < 100000) begin
            @(posedge clk);
            waited++;
        end
        repeat (32) @(posedge clk);
        if (sb.expected_pixels.size() != 0) begin
            sb.report_mismatch("pixels never delivered",
                               longint'(sb.expected_pixels.size()), 0);
        end

        $display("Ran %0d commands: %0d starts, %0d steps (%0d with no ellipse active)",
                 n_sent, sb.starts, sb.steps, sb.idle_steps);
        $display("Drew %0d ellipses to the end, compared %0d pixels, %0d mismatches",
                 sb.finished, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mer_pkg.sv
rtl/mer_front.sv
rtl/mer_emit.sv
rtl/mer_core.sv
rtl/midpoint_ellipse_rasterizer.sv
rtl/mer_checker.sv
tb/tb.sv
